@@ hw/rtl/mrt_pkg.sv @@
// Miller-Rabin trial package: shared widths and defaults.
// No dependencies; imported by mrt_modmul and miller_rabin_trial_unit.
package mrt_pkg;

  localparam int FieldWidth        = 31;
  localparam int NumberBitsDefault = 31;

endpackage

@@ hw/rtl/miller_rabin_trial_unit.sv @@
// Miller-Rabin trial top level: sequencer around one shared modular multiplier.
// Depends on mrt_pkg and mrt_modmul.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  input    | start, busy                | candidate_i, random_value_i
//  result   | valid_o (one-cycle strobe) | probably_prime_o
//
// Candidates 0..4 give their verdict in the cycle after the transfer, busy stays low.
// Otherwise the sequencer strips the twos from n-1, then runs each modular
// product in mrt_modmul, one at a time: one reduction of the random value, up
// to two products per bit of d, and up to r-1 squarings.
// busy is high from the cycle after the transfer until the result strobe; the
// receiver cannot stall and no reset sweep is needed.
module miller_rabin_trial_unit #(
  parameter int NumberBits = mrt_pkg::NumberBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [mrt_pkg::FieldWidth-1:0] candidate_i,
  input  logic [mrt_pkg::FieldWidth-1:0] random_value_i,
  output logic                           valid_o,
  output logic                           probably_prime_o
);
  import mrt_pkg::*;

  localparam int RW = $clog2(NumberBits);

  typedef enum logic [3:0] {
    S_IDLE, S_STRIP, S_RED, S_RED_W, S_POW, S_POW_MW, S_POW_SQ, S_POW_SW,
    S_CHK, S_SQ, S_SQ_W
  } state_e;

  state_e                state_q;
  logic                  valid_q, prime_q;
  logic [NumberBits-1:0] n_q, nm1_q, exp_q, rnd_q, x_q, base_q;
  logic [RW-1:0]         r_q;

  logic [NumberBits-1:0] n_in, rnd_in, exp_shr;
  logic                  mm_start, mm_done;
  logic [NumberBits-1:0] mm_a, mm_b, mm_m, mm_res;

  assign n_in    = NumberBits'(candidate_i);
  assign rnd_in  = NumberBits'(random_value_i);
  assign exp_shr = exp_q >> 1;

  always_comb begin
    mm_start = 1'b0;
    mm_a     = x_q;
    mm_b     = base_q;
    mm_m     = n_q;
    unique case (state_q)
      S_RED: begin
        mm_start = 1'b1;
        mm_a     = NumberBits'(1);
        mm_b     = rnd_q;
        mm_m     = n_q - NumberBits'(4);
      end
      S_POW: begin
        mm_start = (exp_q != '0) && exp_q[0];
      end
      S_POW_SQ: begin
        mm_start = (exp_shr != '0);
        mm_a     = base_q;
      end
      S_SQ: begin
        mm_start = (r_q != '0);
        mm_b     = x_q;
      end
      default: ;
    endcase
  end

  mrt_modmul #(
    .NumberBits(NumberBits)
  ) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .m_i     (mm_m),
    .done_o  (mm_done),
    .result_o(mm_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      prime_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            if (n_in <= NumberBits'(4)) begin
              valid_q <= 1'b1;
              prime_q <= (n_in == NumberBits'(2)) || (n_in == NumberBits'(3));
            end else begin
              state_q <= S_STRIP;
            end
          end
        end
        S_STRIP: begin
          if (exp_q[0]) begin
            state_q <= S_RED;
          end
        end
        S_RED:    state_q <= S_RED_W;
        S_RED_W: begin
          if (mm_done) begin
            state_q <= S_POW;
          end
        end
        S_POW: begin
          if (exp_q == '0) begin
            state_q <= S_CHK;
          end else if (exp_q[0]) begin
            state_q <= S_POW_MW;
          end else begin
            state_q <= S_POW_SQ;
          end
        end
        S_POW_MW: begin
          if (mm_done) begin
            state_q <= S_POW_SQ;
          end
        end
        S_POW_SQ: state_q <= (exp_shr != '0) ? S_POW_SW : S_CHK;
        S_POW_SW: begin
          if (mm_done) begin
            state_q <= S_POW;
          end
        end
        S_CHK: begin
          if ((x_q == NumberBits'(1)) || (x_q == nm1_q)) begin
            valid_q <= 1'b1;
            prime_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (r_q == '0) begin
            valid_q <= 1'b1;
            prime_q <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_SQ_W;
          end
        end
        S_SQ_W: begin
          if (mm_done) begin
            if (mm_res == NumberBits'(1)) begin
              valid_q <= 1'b1;
              prime_q <= 1'b0;
              state_q <= S_IDLE;
            end else if (mm_res == nm1_q) begin
              valid_q <= 1'b1;
              prime_q <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_SQ;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        n_q   <= n_in;
        nm1_q <= n_in - NumberBits'(1);
        exp_q <= n_in - NumberBits'(1);
        rnd_q <= rnd_in;
        r_q   <= '0;
      end
      S_STRIP: begin
        if (!exp_q[0]) begin
          exp_q <= exp_shr;
          r_q   <= r_q + RW'(1);
        end
      end
      S_RED_W: begin
        if (mm_done) begin
          base_q <= mm_res + NumberBits'(2);
          x_q    <= NumberBits'(1);
        end
      end
      S_POW_MW: begin
        if (mm_done) begin
          x_q <= mm_res;
        end
      end
      S_POW_SQ: exp_q <= exp_shr;
      S_POW_SW: begin
        if (mm_done) begin
          base_q <= mm_res;
        end
      end
      S_CHK: begin
        if (r_q != '0) begin
          r_q <= r_q - RW'(1);
        end
      end
      S_SQ_W: begin
        if (mm_done) begin
          x_q <= mm_res;
          r_q <= r_q - RW'(1);
        end
      end
      default: ;
    endcase
  end

  assign busy             = (state_q != S_IDLE);
  assign valid_o          = valid_q;
  assign probably_prime_o = prime_q;

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result strobe while busy");
  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start)) else $error("busy without a transfer");
  a_busy_ends_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o) else $error("trial ended without a result");
  a_base_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POW) |-> (base_q < n_q) && (x_q < n_q))
    else $error("operand out of residue range");

endmodule

@@ hw/rtl/mrt_modmul.sv @@
// Bit-serial modular multiplier: result = (a * b) mod m, one bit of b per cycle.
// Depends on mrt_pkg. Requires a <= m and m >= 1.
module mrt_modmul #(
  parameter int NumberBits = mrt_pkg::NumberBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NumberBits-1:0] a_i,
  input  logic [NumberBits-1:0] b_i,
  input  logic [NumberBits-1:0] m_i,
  output logic                  done_o,
  output logic [NumberBits-1:0] result_o
);
  import mrt_pkg::*;

  localparam int CntW = $clog2(NumberBits + 1);

  logic                  busy_q, done_q;
  logic [CntW-1:0]       cnt_q;
  logic [NumberBits-1:0] acc_q, a_q, b_q, m_q;
  logic [NumberBits-1:0] acc_d;
  logic [NumberBits:0]   dbl, dbl_r, sum, sum_r, m_ext;

  always_comb begin
    m_ext = {1'b0, m_q};
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum   = dbl_r + (b_q[NumberBits-1] ? {1'b0, a_q} : '0);
    sum_r = (sum >= m_ext) ? sum - m_ext : sum;
    acc_d = sum_r[NumberBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumberBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
      m_q   <= m_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= b_q << 1;
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> acc_q < m_q) else $error("accumulator left the residue range");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q)) else $error("done without a running product");

endmodule
